### design/fixed_array_insert_erase_assert.svh
// ----------------------------------------------------------------------------
// fixed_array_insert_erase assertion macros
// Shared concurrent assertion forms for the array block checkers.
// ----------------------------------------------------------------------------
`ifndef FIXED_ARRAY_INSERT_ERASE_ASSERT_SVH
`define FIXED_ARRAY_INSERT_ERASE_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define FAC_ASSERT_IMP(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("fixed_array_insert_erase: check failed");

// Next-cycle implication, disabled during reset.
`define FAC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("fixed_array_insert_erase: check failed");

`endif

### design/fac_pkg.sv
// ----------------------------------------------------------------------------
// fac_pkg
// Types, codes and sizes shared by the fixed array insert/erase block.
// ----------------------------------------------------------------------------
package fac_pkg;

	localparam int DEPTH_DEF     = 16;
	localparam int WORD_BITS_DEF = 32;
	localparam int VALUE_BITS    = 32;
	localparam int POS_BITS      = 8;
	localparam int OP_BITS       = 3;
	localparam int LEN_CFG_BITS  = 5;
	localparam int CMP_BITS      = 9;
	localparam int WIDE_BITS     = 128;

	localparam logic [LEN_CFG_BITS-1:0] LEN_RESET = 5'd16;

	localparam logic [OP_BITS-1:0] OP_READ   = 3'd0;
	localparam logic [OP_BITS-1:0] OP_WRITE  = 3'd1;
	localparam logic [OP_BITS-1:0] OP_INSERT = 3'd2;
	localparam logic [OP_BITS-1:0] OP_ERASE  = 3'd3;
	localparam logic [OP_BITS-1:0] OP_REMOVE = 3'd4;

	typedef struct packed {
		logic [OP_BITS-1:0]           operation;
		logic signed [POS_BITS-1:0]   position;
		logic signed [VALUE_BITS-1:0] operand_value;
	} in_beat_t;

	typedef struct packed {
		logic signed [VALUE_BITS-1:0] result_value;
		logic                         key_found;
		logic                         index_error;
	} out_beat_t;

	typedef struct packed {
		logic wr;
		logic ins;
		logic ers;
		logic rmv;
	} cell_ctl_t;

endpackage

### design/fixed_array_insert_erase.sv
// ----------------------------------------------------------------------------
// fixed_array_insert_erase
// Fixed-length array of signed words with read, write, insert, erase and
// remove-by-key, built as a row of slot cells.
// ----------------------------------------------------------------------------
// Every request is completed directly: all slot cells shift or load together
// at the edge that accepts the beat, and the result is registered at that
// same edge, so one beat is taken per cycle while the output side keeps up.
// The longest path is the ripple of the remove-match and read-select chains
// through all DEPTH cells. The store is cleared by reset at once; there is no
// clearing pass.
// ----------------------------------------------------------------------------
module fixed_array_insert_erase #(
	parameter int DEPTH     = fac_pkg::DEPTH_DEF,
	parameter int WORD_BITS = fac_pkg::WORD_BITS_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                cfg_wr_en,
	input  logic [fac_pkg::LEN_CFG_BITS-1:0]    cfg_wr_data,
	input  logic                                in_valid,
	output logic                                in_stall,
	input  fac_pkg::in_beat_t                   in_beat,
	output logic                                out_valid,
	input  logic                                out_stall,
	output fac_pkg::out_beat_t                  out_beat
);
	import fac_pkg::*;

	localparam int IDX_BITS = $clog2(DEPTH);
	localparam int LEN_BITS = $clog2(DEPTH+1);

	logic [LEN_CFG_BITS-1:0] active_length_q;
	logic                    out_valid_q;
	out_beat_t               out_beat_q;

	logic                       fire;
	logic [LEN_BITS-1:0]        eff_len;
	logic signed [CMP_BITS-1:0] pos_s;
	logic signed [CMP_BITS-1:0] len_s;
	logic signed [CMP_BITS-1:0] sum_s;
	logic                       ok;
	logic [IDX_BITS-1:0]        idx;
	logic [WIDE_BITS-1:0]       op_wide;
	logic [WORD_BITS-1:0]       val;
	logic [WIDE_BITS-1:0]       rd_wide;
	logic [WIDE_BITS-1:0]       val_wide;
	cell_ctl_t                  ctl;
	out_beat_t                  res;

	logic [WORD_BITS-1:0] slot_w  [DEPTH];
	logic [WORD_BITS-1:0] rd_ch   [DEPTH+1];
	logic                 mat_ch  [DEPTH+1];

	assign in_stall  = out_valid_q & out_stall;
	assign fire      = in_valid & ~in_stall;
	assign out_valid = out_valid_q;
	assign out_beat  = out_beat_q;

	always_comb begin
		if (CMP_BITS'(active_length_q) > CMP_BITS'(DEPTH)) begin
			eff_len = LEN_BITS'(DEPTH);
		end else begin
			eff_len = LEN_BITS'(active_length_q);
		end
	end

	assign pos_s    = CMP_BITS'(in_beat.position);
	assign len_s    = $signed(CMP_BITS'(eff_len));
	assign sum_s    = pos_s[CMP_BITS-1] ? pos_s + len_s : pos_s;
	assign ok       = !sum_s[CMP_BITS-1] && (sum_s < len_s);
	assign idx      = sum_s[IDX_BITS-1:0];
	assign op_wide  = {{(WIDE_BITS-VALUE_BITS){1'b0}}, in_beat.operand_value};
	assign val      = op_wide[WORD_BITS-1:0];
	assign val_wide = {{(WIDE_BITS-WORD_BITS){1'b0}}, val};
	assign rd_wide  = {{(WIDE_BITS-WORD_BITS){1'b0}}, rd_ch[DEPTH]};

	always_comb begin
		ctl = '0;
		res = '0;
		unique case (in_beat.operation)
			OP_READ: begin
				res.index_error  = !ok;
				res.result_value = ok ? rd_wide[VALUE_BITS-1:0] : '0;
			end
			OP_WRITE: begin
				ctl.wr           = fire && ok;
				res.index_error  = !ok;
				res.result_value = ok ? val_wide[VALUE_BITS-1:0] : '0;
			end
			OP_INSERT: begin
				ctl.ins          = fire && ok;
				res.index_error  = !ok;
				res.result_value = ok ? val_wide[VALUE_BITS-1:0] : '0;
			end
			OP_ERASE: begin
				ctl.ers          = fire && ok;
				res.index_error  = !ok;
				res.result_value = ok ? rd_wide[VALUE_BITS-1:0] : '0;
			end
			OP_REMOVE: begin
				ctl.rmv          = fire;
				res.key_found    = mat_ch[DEPTH];
			end
			default: begin
				res = '0;
			end
		endcase
	end

	assign rd_ch[0]  = '0;
	assign mat_ch[0] = 1'b0;

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [WORD_BITS-1:0] left_w;
		logic [WORD_BITS-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = slot_w[i-1];
		end

		if (i == DEPTH-1) begin : g_last
			assign right_w = '0;
		end else begin : g_body
			assign right_w = slot_w[i+1];
		end

		fac_cell #(
			.DEPTH     (DEPTH),
			.WORD_BITS (WORD_BITS),
			.SLOT      (i)
		) u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.ctl       (ctl),
			.idx       (idx),
			.len       (eff_len),
			.val       (val),
			.left      (left_w),
			.right     (right_w),
			.match_in  (mat_ch[i]),
			.rd_in     (rd_ch[i]),
			.slot      (slot_w[i]),
			.match_out (mat_ch[i+1]),
			.rd_out    (rd_ch[i+1])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_length_q <= LEN_RESET;
		end else if (cfg_wr_en) begin
			active_length_q <= cfg_wr_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fire) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			out_beat_q <= res;
		end
	end

endmodule

### design/fac_cell.sv
// ----------------------------------------------------------------------------
// fac_cell
// One array slot: holds its word, takes a neighbor's word on shifts, and
// extends the remove-match and read-select chains.
// ----------------------------------------------------------------------------
module fac_cell #(
	parameter int DEPTH     = fac_pkg::DEPTH_DEF,
	parameter int WORD_BITS = fac_pkg::WORD_BITS_DEF,
	parameter int SLOT      = 0
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  fac_pkg::cell_ctl_t             ctl,
	input  logic [$clog2(DEPTH)-1:0]       idx,
	input  logic [$clog2(DEPTH+1)-1:0]     len,
	input  logic [WORD_BITS-1:0]           val,
	input  logic [WORD_BITS-1:0]           left,
	input  logic [WORD_BITS-1:0]           right,
	input  logic                           match_in,
	input  logic [WORD_BITS-1:0]           rd_in,
	output logic [WORD_BITS-1:0]           slot,
	output logic                           match_out,
	output logic [WORD_BITS-1:0]           rd_out
);
	import fac_pkg::*;

	localparam int IDX_BITS = $clog2(DEPTH);
	localparam int LEN_BITS = $clog2(DEPTH+1);
	localparam logic [IDX_BITS-1:0] SELF     = IDX_BITS'(SLOT);
	localparam logic [LEN_BITS-1:0] SELF_LEN = LEN_BITS'(SLOT);
	localparam logic [LEN_BITS-1:0] NEXT_LEN = LEN_BITS'(SLOT + 1);

	logic [WORD_BITS-1:0] slot_q;
	logic [WORD_BITS-1:0] slot_d;
	logic active;
	logic is_last;
	logic at;
	logic after;

	assign active    = SELF_LEN < len;
	assign is_last   = NEXT_LEN == len;
	assign at        = idx == SELF;
	assign after     = SELF > idx;
	assign match_out = match_in | (active && (slot_q == val));
	assign rd_out    = rd_in | ({WORD_BITS{at}} & slot_q);
	assign slot      = slot_q;

	always_comb begin
		slot_d = slot_q;
		if (ctl.wr && at) begin
			slot_d = val;
		end else if (ctl.ins && at) begin
			slot_d = val;
		end else if (ctl.ins && after && active) begin
			slot_d = left;
		end else if (ctl.ers && (at || after) && active) begin
			slot_d = is_last ? '0 : right;
		end else if (ctl.rmv && match_out && active && !is_last) begin
			slot_d = right;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			slot_q <= '0;
		end else begin
			slot_q <= slot_d;
		end
	end

endmodule

### design/fac_checker.sv
// ----------------------------------------------------------------------------
// fac_checker
// Port-level checks on the fixed array insert/erase block, bound to the top.
// ----------------------------------------------------------------------------
`include "fixed_array_insert_erase_assert.svh"

module fac_checker (
	input logic               clk,
	input logic               arst_n,
	input logic               in_valid,
	input logic               in_stall,
	input fac_pkg::in_beat_t  in_beat,
	input logic               out_valid,
	input logic               out_stall,
	input fac_pkg::out_beat_t out_beat
);
	import fac_pkg::*;

	`FAC_ASSERT_NEXT(a_beat_gives_result, clk, arst_n, in_valid && !in_stall, out_valid)
	`FAC_ASSERT_IMP(a_stall_only_when_full, clk, arst_n, in_stall, out_valid && out_stall)
	`FAC_ASSERT_IMP(a_flags_exclusive, clk, arst_n, out_valid, !(out_beat.key_found && out_beat.index_error))
	`FAC_ASSERT_IMP(a_error_zero_value, clk, arst_n, out_valid && out_beat.index_error, out_beat.result_value == '0)
	`FAC_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid && $stable(out_beat))

endmodule

bind fixed_array_insert_erase fac_checker u_fac_checker (.*);

### verif/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking regression for fixed_array_insert_erase. A queue-fed driver
// sends request beats in random bursts, an array model predicts each result
// beat, and a monitor compares every result beat with the oldest prediction
// while the receiver stalls on its own pattern. Phases step the active
// length through its extremes, with the length written only while idle.
// ----------------------------------------------------------------------------
module tb;
	import fac_pkg::*;

	localparam int SLOTS       = DEPTH_DEF;
	localparam int PHASE_BEATS = 160;
	localparam int LONG_HOLD   = 300;
	localparam int PHASES      = 10;

	localparam logic [OP_BITS-1:0] OP_SPARE5 = 3'd5;
	localparam logic [OP_BITS-1:0] OP_SPARE6 = 3'd6;
	localparam logic [OP_BITS-1:0] OP_SPARE7 = 3'd7;

	typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_t;

	logic                    clk         = 1'b0;
	logic                    arst_n      = 1'b0;
	logic                    cfg_wr_en   = 1'b0;
	logic [LEN_CFG_BITS-1:0] cfg_wr_data = '0;
	logic                    in_valid    = 1'b0;
	logic                    in_stall;
	in_beat_t                in_beat     = '0;
	logic                    out_valid;
	logic                    out_stall   = 1'b0;
	out_beat_t               out_beat;

	in_beat_t                requests_queued[$];
	out_beat_t               results_due[$];
	logic [VALUE_BITS-1:0]   slot_model[SLOTS];
	logic [LEN_CFG_BITS-1:0] model_len      = LEN_RESET;
	int                      mismatch_count = 0;
	int                      hold_req       = 0;

	fixed_array_insert_erase DUT (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_wr_en  (cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.in_valid   (in_valid),
		.in_stall   (in_stall),
		.in_beat    (in_beat),
		.out_valid  (out_valid),
		.out_stall  (out_stall),
		.out_beat   (out_beat)
	);

	always #4 clk = ~clk;

	function automatic out_beat_t apply_to_array(in_beat_t req);
		out_beat_t rsp;
		int        eff;
		int        pos;
		int        i;
		logic      hit;
		rsp = '0;
		eff = (model_len > SLOTS) ? SLOTS : int'(model_len);
		hit = 1'b0;
		pos = $signed(req.position);
		case (req.operation)
			OP_REMOVE: begin
				for (i = 0; i < eff && !hit; i++) begin
					if (slot_model[i] == req.operand_value) begin
						for (int j = i; j + 1 < eff; j++)
							slot_model[j] = slot_model[j + 1];
						hit = 1'b1;
					end
				end
				rsp.key_found = hit;
			end
			OP_READ, OP_WRITE, OP_INSERT, OP_ERASE: begin
				if (pos < 0)
					pos += eff;
				if (pos < 0 || pos >= eff) begin
					rsp.index_error = 1'b1;
				end else begin
					case (req.operation)
						OP_READ: rsp.result_value = slot_model[pos];
						OP_WRITE: begin
							slot_model[pos] = req.operand_value;
							rsp.result_value = req.operand_value;
						end
						OP_INSERT: begin
							for (i = eff - 1; i > pos; i--)
								slot_model[i] = slot_model[i - 1];
							slot_model[pos] = req.operand_value;
							rsp.result_value = req.operand_value;
						end
						default: begin
							rsp.result_value = slot_model[pos];
							for (i = pos; i + 1 < eff; i++)
								slot_model[i] = slot_model[i + 1];
							slot_model[eff - 1] = '0;
						end
					endcase
				end
			end
			default: ;
		endcase
		return rsp;
	endfunction

	function automatic in_beat_t mk_req(logic [OP_BITS-1:0] op, int pos,
			logic [VALUE_BITS-1:0] val);
		in_beat_t req;
		req.operation     = op;
		req.position      = POS_BITS'(pos);
		req.operand_value = val;
		return req;
	endfunction

	function automatic in_beat_t random_req(int unsigned len);
		in_beat_t    req;
		int unsigned eff;
		int unsigned pick;
		eff = (len > SLOTS) ? SLOTS : len;
		if ($urandom_range(0, 19) == 0)
			req.operation = OP_BITS'($urandom_range(OP_SPARE5, OP_SPARE7));
		else
			req.operation = OP_BITS'($urandom_range(OP_READ, OP_REMOVE));
		pick = $urandom_range(0, 9);
		if (pick < 4 && eff > 0)
			req.position = POS_BITS'($urandom_range(0, eff - 1));
		else if (pick < 7 && eff > 0)
			req.position = POS_BITS'(-int'($urandom_range(1, eff)));
		else
			req.position = POS_BITS'($urandom);
		if ($urandom_range(0, 9) < 6) begin
			case ($urandom_range(0, 7))
				0: req.operand_value = 32'h0000_0000;
				1: req.operand_value = 32'h0000_0001;
				2: req.operand_value = 32'hFFFF_FFFF;
				3: req.operand_value = 32'h7FFF_FFFF;
				4: req.operand_value = 32'h8000_0000;
				5: req.operand_value = 32'h0000_0005;
				6: req.operand_value = 32'h0000_1234;
				default: req.operand_value = 32'hA5A5_A5A5;
			endcase
		end else begin
			req.operand_value = $urandom;
		end
		return req;
	endfunction

	task automatic wait_idle();
		do
			@(negedge clk);
		while (requests_queued.size() != 0 || in_valid || results_due.size() != 0);
		repeat (2) @(posedge clk);
	endtask

	always @(posedge clk) begin : drive_req
		static int burst_left = 0;
		static int gap_left   = 0;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else begin
			if (in_valid && !in_stall)
				results_due.push_back(apply_to_array(in_beat));
			if (!in_valid || !in_stall) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (requests_queued.size() > 0) begin
					in_beat  <= requests_queued.pop_front();
					in_valid <= 1'b1;
					if (burst_left > 0) begin
						burst_left--;
					end else begin
						burst_left = $urandom_range(1, 48);
						gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
					end
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin : drive_stall
		static int          hold_left = 0;
		static int          hold_seen = 0;
		static int          mode_left = 0;
		static int          tick      = 0;
		static stall_mode_t mode      = STALL_NONE;
		if (!arst_n) begin
			out_stall <= 1'b0;
		end else begin
			tick++;
			if (hold_left == 0 && hold_seen != hold_req) begin
				hold_seen = hold_req;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				out_stall <= 1'b1;
			end else begin
				if (mode_left == 0) begin
					mode      = stall_mode_t'($urandom_range(STALL_NONE, STALL_PERIODIC));
					mode_left = $urandom_range(20, 80);
				end else begin
					mode_left--;
				end
				case (mode)
					STALL_NONE:  out_stall <= 1'b0;
					STALL_LIGHT: out_stall <= ($urandom_range(0, 3) == 0);
					STALL_HEAVY: out_stall <= ($urandom_range(0, 9) < 7);
					default:     out_stall <= (tick % 4 == 0);
				endcase
			end
		end
	end

	always @(posedge clk) begin : check_rsp
		out_beat_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (results_due.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= 10)
					$display("unexpected result beat: value %h found %0b error %0b",
						out_beat.result_value, out_beat.key_found, out_beat.index_error);
			end else begin
				want = results_due.pop_front();
				if (out_beat.result_value !== want.result_value ||
						out_beat.key_found !== want.key_found ||
						out_beat.index_error !== want.index_error) begin
					mismatch_count++;
					if (mismatch_count <= 10)
						$display("mismatch: expected value %h found %0b error %0b, ",
							want.result_value, want.key_found, want.index_error,
							"got value %h found %0b error %0b",
							out_beat.result_value, out_beat.key_found, out_beat.index_error);
				end
			end
		end
	end

	initial begin : run_phases
		logic [LEN_CFG_BITS-1:0] lens[PHASES];
		lens[0] = 5'd1;
		lens[1] = 5'd0;
		lens[2] = 5'd31;
		lens[3] = 5'd8;
		lens[4] = 5'd17;
		lens[5] = 5'd2;
		lens[6] = 5'd16;
		for (int k = 7; k < PHASES; k++)
			lens[k] = LEN_CFG_BITS'($urandom_range(0, 31));
		for (int k = 0; k < SLOTS; k++)
			slot_model[k] = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		requests_queued.push_back(mk_req(OP_READ,     0,   32'h0000_0000));
		requests_queued.push_back(mk_req(OP_WRITE,    0,   32'h7FFF_FFFF));
		requests_queued.push_back(mk_req(OP_WRITE,   -1,   32'h8000_0000));
		requests_queued.push_back(mk_req(OP_WRITE,    7,   32'hDEAD_BEEF));
		requests_queued.push_back(mk_req(OP_READ,   -16,   32'hFFFF_FFFF));
		requests_queued.push_back(mk_req(OP_READ,    15,   32'h0000_0000));
		requests_queued.push_back(mk_req(OP_READ,    16,   32'h0000_0000));
		requests_queued.push_back(mk_req(OP_READ,   -17,   32'h0000_0000));
		requests_queued.push_back(mk_req(OP_WRITE,  127,   32'h1111_1111));
		requests_queued.push_back(mk_req(OP_INSERT, -128,  32'h2222_2222));
		requests_queued.push_back(mk_req(OP_ERASE,   64,   32'h0000_0000));
		requests_queued.push_back(mk_req(OP_INSERT,   0,   32'h0000_0001));
		requests_queued.push_back(mk_req(OP_INSERT,  -1,   32'h55AA_55AA));
		requests_queued.push_back(mk_req(OP_ERASE,    0,   32'h0000_0000));
		requests_queued.push_back(mk_req(OP_ERASE,   -1,   32'h0000_0000));
		requests_queued.push_back(mk_req(OP_REMOVE,   3,   32'hDEAD_BEEF));
		requests_queued.push_back(mk_req(OP_REMOVE,   0,   32'h1357_9BDF));
		requests_queued.push_back(mk_req(OP_REMOVE,  -1,   32'h0000_0000));
		requests_queued.push_back(mk_req(OP_SPARE5,   3,   32'hFFFF_FFFF));
		requests_queued.push_back(mk_req(OP_SPARE6,  -2,   32'h8000_0000));
		requests_queued.push_back(mk_req(OP_SPARE7, 127,   32'h7FFF_FFFF));
		requests_queued.push_back(mk_req(OP_READ,     0,   32'h0000_0000));
		requests_queued.push_back(mk_req(OP_READ,    -1,   32'h0000_0000));

		for (int p = 0; p <= PHASES; p++) begin
			if (p > 0) begin
				wait_idle();
				cfg_wr_en   <= 1'b1;
				cfg_wr_data <= lens[p - 1];
				@(posedge clk);
				cfg_wr_en <= 1'b0;
				model_len = lens[p - 1];
				@(negedge clk);
			end
			for (int n = 0; n < PHASE_BEATS; n++)
				requests_queued.push_back(random_req(model_len));
			if (p == 0 || p == 6)
				hold_req <= hold_req + 1;
		end

		wait_idle();
		repeat (8) @(posedge clk);
		if (mismatch_count == 0 && results_due.size() == 0)
			$display("fixed_array_insert_erase regression: pass");
		else
			$display("fixed_array_insert_erase regression: fail");
		$finish;
	end

	initial begin : watchdog
		#5_000_000;
		$display("fixed_array_insert_erase regression: fail");
		$finish;
	end

endmodule

### filelist.f
+incdir+design
design/fac_pkg.sv
design/fac_cell.sv
design/fixed_array_insert_erase.sv
design/fac_checker.sv
verif/tb.sv
